// ===== hw/rtl/prw_pkg.sv =====
// prw_pkg: shared types, sizes and codes for the packet reorder window.
// Used by every module of the block except prw_ram; depends on nothing.

package prw_pkg;

  // Window size in slots (2 to 64)
  localparam int WINDOW_DEPTH = 64;
  localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int IDX_W        = 16;
  localparam int HANDLE_W     = 16;
  localparam int CNT_W        = 7;

  // Input kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // Result kinds
  localparam logic [1:0] RK_RELEASE = 2'd0;
  localparam logic [1:0] RK_REPORT  = 2'd1;
  localparam logic [1:0] RK_REJECT  = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [IDX_W-1:0]    packet_index;
    logic [HANDLE_W-1:0] payload_handle;
    logic                is_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [IDX_W-1:0]    out_index;
    logic [HANDLE_W-1:0] out_handle;
    logic                frame_done;
    logic [CNT_W-1:0]    dropped_count;
    logic                last_of_run;
  } out_item_t;

  // One slot of the payload store
  typedef struct packed {
    logic                last;
    logic [HANDLE_W-1:0] handle;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOOK,
    ST_READ,
    ST_SCAN,
    ST_REPORT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic store;
    logic reject;
    logic release_pkt;
    logic scan_init;
    logic scan_step;
    logic report;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;
    logic accept_ok;
    logic head_valid;
    logic rel_more;
    logic scan_more;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/prw_ram.sv =====
// prw_ram: generic single-write, single-read RAM with registered read data.
// Self-contained; no package dependency.

module prw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/prw_datapath.sv =====
// prw_datapath: window state, slot valid bits, payload store, loss scan and
// result register. Depends on prw_pkg and prw_ram.

module prw_datapath (
  input  logic                clk,
  input  logic                rst,
  input  prw_pkg::in_item_t   pkt,
  input  prw_pkg::ctrl_cmd_t  cmd,
  output prw_pkg::dp_status_t status,
  output logic                res_valid,
  input  logic                res_stall,
  output prw_pkg::out_item_t  res
);

  localparam logic [prw_pkg::SLOT_W:0] DEPTH_EXT = (prw_pkg::SLOT_W + 1)'(prw_pkg::WINDOW_DEPTH);
  localparam logic [prw_pkg::IDX_W:0]  DEPTH_IDX = (prw_pkg::IDX_W + 1)'(prw_pkg::WINDOW_DEPTH);
  localparam logic [prw_pkg::SLOT_W-1:0] SLOT_LAST =
    prw_pkg::SLOT_W'(prw_pkg::WINDOW_DEPTH - 1);

  // Slot after s, wrapping at the window depth
  function automatic logic [prw_pkg::SLOT_W-1:0] slot_inc(input logic [prw_pkg::SLOT_W-1:0] s);
    logic [prw_pkg::SLOT_W-1:0] r;
    r = (s == SLOT_LAST) ? '0 : s + 1'b1;
    return r;
  endfunction

  prw_pkg::in_item_t                 cur;
  logic [prw_pkg::IDX_W-1:0]         exp_index;
  logic [prw_pkg::SLOT_W-1:0]        exp_slot;
  logic [prw_pkg::IDX_W-1:0]         highest;
  logic [prw_pkg::WINDOW_DEPTH-1:0]  slot_valid;
  logic [prw_pkg::CNT_W-1:0]         scan_off;
  logic [prw_pkg::CNT_W-1:0]         span;
  logic [prw_pkg::CNT_W-1:0]         drop_cnt;
  logic [prw_pkg::SLOT_W-1:0]        scan_slot;

  logic [prw_pkg::IDX_W-1:0]         diff;
  logic [prw_pkg::IDX_W:0]           win_end;
  logic                              in_win;
  logic [prw_pkg::SLOT_W:0]          slot_sum;
  logic [prw_pkg::SLOT_W:0]          slot_wrap;
  logic [prw_pkg::SLOT_W-1:0]        slot_in;
  logic [prw_pkg::IDX_W-1:0]         top;
  logic [prw_pkg::IDX_W-1:0]         span_full;
  logic [prw_pkg::ENTRY_W-1:0]       rdata_raw;
  prw_pkg::slot_entry_t              rdata;
  prw_pkg::slot_entry_t              wentry;
  logic                              out_free;

  // Window check and slot of the held packet
  assign diff      = cur.packet_index - exp_index;
  assign win_end   = {1'b0, exp_index} + DEPTH_IDX;
  assign in_win    = (cur.packet_index >= exp_index) && ({1'b0, cur.packet_index} < win_end);
  assign slot_sum  = {1'b0, exp_slot} + {1'b0, diff[prw_pkg::SLOT_W-1:0]};
  assign slot_wrap = slot_sum - DEPTH_EXT;
  assign slot_in   = (slot_sum >= DEPTH_EXT) ? slot_wrap[prw_pkg::SLOT_W-1:0]
                                             : slot_sum[prw_pkg::SLOT_W-1:0];

  // Report bound and scan length
  assign top       = (highest > exp_index) ? highest : exp_index;
  assign span_full = top - exp_index;

  assign out_free  = !res_valid || !res_stall;
  assign rdata     = prw_pkg::slot_entry_t'(rdata_raw);
  assign wentry    = '{last: cur.is_last, handle: cur.payload_handle};

  // Status to controller
  always_comb begin
    status.is_clear   = (cur.kind == prw_pkg::KIND_CLEAR);
    status.accept_ok  = in_win && !slot_valid[slot_in];
    status.head_valid = slot_valid[exp_slot];
    status.rel_more   = !rdata.last && (exp_index != '1) && slot_valid[slot_inc(exp_slot)];
    status.scan_more  = (scan_off != span);
    status.out_free   = out_free;
  end

  // Payload store: written at the packet's slot, read at the expected slot
  prw_ram #(
    .WIDTH (prw_pkg::ENTRY_W),
    .DEPTH (prw_pkg::WINDOW_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (slot_in),
    .wdata (wentry),
    .raddr (exp_slot),
    .rdata (rdata_raw)
  );

  // Window control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      exp_index  <= '0;
      exp_slot   <= '0;
      highest    <= '0;
      res_valid  <= 1'b0;
    end else begin
      // Result register occupancy: a new result wins over the take
      if (cmd.reject || cmd.release_pkt || cmd.report) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (cmd.store) begin
        slot_valid[slot_in] <= 1'b1;
        if (cur.packet_index > highest) begin
          highest <= cur.packet_index;
        end
      end
      if (cmd.release_pkt) begin
        if (rdata.last) begin
          slot_valid <= '0;
          exp_index  <= '0;
          exp_slot   <= '0;
          highest    <= '0;
        end else if (exp_index == '1) begin
          // index wrap: window is empty here
          slot_valid[exp_slot] <= 1'b0;
          exp_index <= '0;
          exp_slot  <= '0;
          highest   <= '0;
        end else begin
          slot_valid[exp_slot] <= 1'b0;
          exp_index <= exp_index + 1'b1;
          exp_slot  <= slot_inc(exp_slot);
        end
      end
      if (cmd.report) begin
        slot_valid <= '0;
        exp_index  <= '0;
        exp_slot   <= '0;
        highest    <= '0;
      end
    end
  end

  // Held input transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= pkt;
    end
  end

  // Loss scan: one slot per cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_off  <= '0;
      drop_cnt  <= '0;
      scan_slot <= exp_slot;
      span      <= span_full[prw_pkg::CNT_W-1:0];
    end else if (cmd.scan_step) begin
      scan_off  <= scan_off + 1'b1;
      scan_slot <= slot_inc(scan_slot);
      if (!slot_valid[scan_slot]) begin
        drop_cnt <= drop_cnt + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      res.result_kind   <= prw_pkg::RK_REJECT;
      res.out_index     <= cur.packet_index;
      res.out_handle    <= cur.payload_handle;
      res.frame_done    <= 1'b0;
      res.dropped_count <= '0;
      res.last_of_run   <= 1'b1;
    end else if (cmd.release_pkt) begin
      res.result_kind   <= prw_pkg::RK_RELEASE;
      res.out_index     <= exp_index;
      res.out_handle    <= rdata.handle;
      res.frame_done    <= rdata.last;
      res.dropped_count <= '0;
      res.last_of_run   <= !status.rel_more;
    end else if (cmd.report) begin
      res.result_kind   <= prw_pkg::RK_REPORT;
      res.out_index     <= top;
      res.out_handle    <= '0;
      res.frame_done    <= 1'b0;
      res.dropped_count <= drop_cnt;
      res.last_of_run   <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/prw_controller.sv =====
// prw_controller: sequencing state machine for the packet reorder window.
// Depends on prw_pkg; drives commands into prw_datapath.

module prw_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                pkt_valid,
  output logic                pkt_stall,
  input  prw_pkg::dp_status_t status,
  output prw_pkg::ctrl_cmd_t  cmd
);

  prw_pkg::state_t state;
  prw_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      prw_pkg::ST_IDLE: begin
        if (pkt_valid) state_next = prw_pkg::ST_EVAL;
      end
      prw_pkg::ST_EVAL: begin
        priority if (status.is_clear) state_next = prw_pkg::ST_SCAN;
        else if (status.accept_ok)    state_next = prw_pkg::ST_LOOK;
        else if (status.out_free)     state_next = prw_pkg::ST_IDLE;
        else                          state_next = prw_pkg::ST_EVAL;
      end
      prw_pkg::ST_LOOK: begin
        state_next = status.head_valid ? prw_pkg::ST_READ : prw_pkg::ST_IDLE;
      end
      prw_pkg::ST_READ: begin
        if (status.out_free) begin
          state_next = status.rel_more ? prw_pkg::ST_LOOK : prw_pkg::ST_IDLE;
        end
      end
      prw_pkg::ST_SCAN: begin
        if (!status.scan_more) state_next = prw_pkg::ST_REPORT;
      end
      prw_pkg::ST_REPORT: begin
        if (status.out_free) state_next = prw_pkg::ST_IDLE;
      end
      default: state_next = prw_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    pkt_stall = 1'b1;
    unique case (state)
      prw_pkg::ST_IDLE: begin
        pkt_stall   = 1'b0;
        cmd.capture = pkt_valid;
      end
      prw_pkg::ST_EVAL: begin
        priority if (status.is_clear) cmd.scan_init = 1'b1;
        else if (status.accept_ok)    cmd.store     = 1'b1;
        else                          cmd.reject    = status.out_free;
      end
      prw_pkg::ST_LOOK: begin
        // read of the expected slot is in flight
      end
      prw_pkg::ST_READ: begin
        cmd.release_pkt = status.out_free;
      end
      prw_pkg::ST_SCAN: begin
        cmd.scan_step = status.scan_more;
      end
      prw_pkg::ST_REPORT: begin
        cmd.report = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/packet_reorder_window.sv =====
// packet_reorder_window: top level, puts one frame's packets back in order.
// Depends on prw_pkg, prw_controller and prw_datapath.
//
// Usage:
//   pkt channel (pkt_valid / pkt_stall / pkt) carries one transaction per
//   packet or clear request. res channel (res_valid / res_stall / res)
//   returns results; each input gives zero or more, the final one of a run
//   has last_of_run set.
//   Transactions are handled one at a time; pkt_stall is high while one is
//   in work. A packet is checked the cycle after acceptance; a rejection is
//   registered onto res from EVAL once the output register is free. A stored
//   packet that starts a run has its slot read in LOOK and is released from
//   READ; each further release of the run passes LOOK and READ again, since
//   the slot RAM has registered read data.
//   A clear scans one slot per cycle over the span from the expected index
//   up to the highest stored index (at most 63 slots), then reports.
//   A result sits in the output register until taken; while res_stall is
//   high it holds, and work that needs a further result waits.
//   Reset (rst, synchronous) empties the window: expected index and highest
//   stored index go to zero, all slot valid bits clear, res_valid drops.

module packet_reorder_window (
  input  logic               clk,
  input  logic               rst,
  input  logic               pkt_valid,
  output logic               pkt_stall,
  input  prw_pkg::in_item_t  pkt,
  output logic               res_valid,
  input  logic               res_stall,
  output prw_pkg::out_item_t res
);

  prw_pkg::ctrl_cmd_t  cmd;
  prw_pkg::dp_status_t status;

  prw_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .status    (status),
    .cmd       (cmd)
  );

  prw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== hw/rtl/prw_checker.sv =====
// prw_checker: port-level assertions for packet_reorder_window.
// Depends on prw_pkg; attached to the top level by the bind below.

module prw_checker (
  input logic               clk,
  input logic               rst,
  input logic               pkt_valid,
  input logic               pkt_stall,
  input prw_pkg::in_item_t  pkt,
  input logic               res_valid,
  input logic               res_stall,
  input prw_pkg::out_item_t res
);

  // A stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // One transaction at a time: the block is busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && !pkt_stall |=> pkt_stall)
    else $error("input taken while previous transaction in work");

  // Only defined result kinds appear
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.result_kind == prw_pkg::RK_RELEASE ||
                   res.result_kind == prw_pkg::RK_REPORT ||
                   res.result_kind == prw_pkg::RK_REJECT))
    else $error("undefined result kind");

  // Reports and rejections stand alone and never end a frame
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind != prw_pkg::RK_RELEASE |->
      res.last_of_run && !res.frame_done)
    else $error("report or rejection not a single result");

  // A frame end closes its run
  a_done_closes_run: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_done |-> res.last_of_run)
    else $error("frame end not last of run");

endmodule

bind packet_reorder_window prw_checker u_prw_checker (
  .clk       (clk),
  .rst       (rst),
  .pkt_valid (pkt_valid),
  .pkt_stall (pkt_stall),
  .pkt       (pkt),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for packet_reorder_window. Directed table rows check
// fixed results or a behavioral model of the reorder window; random frames are
// checked against the model. Depends on prw_pkg and packet_reorder_window.

module tb;

  localparam int CYCLE_LIMIT  = 6000000;
  localparam int SETTLE       = 80;      // longest clear scan plus margin
  localparam int RANDOM_ITEMS = 340;
  localparam int MAX_WAIT     = 16;

  // How a table row gets its expected results
  localparam int WANT_MODEL = -1;
  localparam int WANT_NONE  = 0;
  localparam int WANT_ONE   = 1;

  typedef enum int {NZ_CLEAR, NZ_REPEAT, NZ_STALE, NZ_BEYOND, NZ_ANY} noise_t;

  typedef struct {
    prw_pkg::in_item_t  item;
    int                 nwant;
    prw_pkg::out_item_t want;
  } stim_row_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               pkt_valid = 1'b0;
  logic               pkt_stall;
  prw_pkg::in_item_t  pkt       = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  prw_pkg::out_item_t res;

  int unsigned cycle_count = 0;
  int          fails       = 0;
  bit          tx_idle     = 1'b1;
  bit          rx_idle     = 1'b1;
  int unsigned rx_wait     = 0;
  int unsigned rx_draw;

  // Model of the window
  logic        win_valid  [prw_pkg::WINDOW_DEPTH];
  logic [15:0] win_handle [prw_pkg::WINDOW_DEPTH];
  logic        win_last   [prw_pkg::WINDOW_DEPTH];
  logic [15:0] next_idx;
  logic [15:0] top_idx;

  prw_pkg::out_item_t due_results[$];
  stim_row_t          dir_rows[$];

  packet_reorder_window DUT (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic prw_pkg::in_item_t pkt_of(logic kind, logic [15:0] idx,
                                               logic [15:0] handle, logic last);
    prw_pkg::in_item_t it;
    it.kind           = kind;
    it.packet_index   = idx;
    it.payload_handle = handle;
    it.is_last        = last;
    return it;
  endfunction

  function automatic prw_pkg::out_item_t res_of(logic [1:0] rk, logic [15:0] idx,
                                                logic [15:0] handle, logic done,
                                                logic [6:0] dropped, logic run_end);
    prw_pkg::out_item_t r;
    r.result_kind   = rk;
    r.out_index     = idx;
    r.out_handle    = handle;
    r.frame_done    = done;
    r.dropped_count = dropped;
    r.last_of_run   = run_end;
    return r;
  endfunction

  function automatic void empty_window_model();
    foreach (win_valid[i]) win_valid[i] = 1'b0;
    next_idx = '0;
    top_idx  = '0;
  endfunction

  // Advances the window model by one transaction; queues its results when keep is set
  function automatic void reorder_step(prw_pkg::in_item_t it, bit keep);
    int unsigned        span_top;
    int unsigned        dropped;
    int unsigned        i;
    int unsigned        s;
    bit                 run_end;
    prw_pkg::out_item_t r;
    if (it.kind == prw_pkg::KIND_CLEAR) begin
      span_top = (top_idx > next_idx) ? top_idx : next_idx;
      dropped  = 0;
      for (i = next_idx; i < span_top && i < next_idx + prw_pkg::WINDOW_DEPTH; i++)
        if (!win_valid[i % prw_pkg::WINDOW_DEPTH]) dropped++;
      if (keep) due_results.push_back(res_of(prw_pkg::RK_REPORT, 16'(span_top), '0, 1'b0,
                                             7'(dropped), 1'b1));
      empty_window_model();
      return;
    end
    // Stale, beyond the window, or duplicate
    s = it.packet_index % prw_pkg::WINDOW_DEPTH;
    if (it.packet_index < next_idx || it.packet_index >= next_idx + prw_pkg::WINDOW_DEPTH ||
        win_valid[s]) begin
      if (keep) due_results.push_back(res_of(prw_pkg::RK_REJECT, it.packet_index,
                                             it.payload_handle, 1'b0, '0, 1'b1));
      return;
    end
    win_valid[s]  = 1'b1;
    win_handle[s] = it.payload_handle;
    win_last[s]   = it.is_last;
    if (it.packet_index > top_idx) top_idx = it.packet_index;
    // Release the contiguous run from the expected index
    run_end = 1'b0;
    while (!run_end && win_valid[next_idx % prw_pkg::WINDOW_DEPTH]) begin
      s = next_idx % prw_pkg::WINDOW_DEPTH;
      r = res_of(prw_pkg::RK_RELEASE, next_idx, win_handle[s], win_last[s], '0, 1'b0);
      win_valid[s] = 1'b0;
      if (win_last[s]) begin
        empty_window_model();
        run_end = 1'b1;
      end else if (next_idx == 16'hFFFF) begin
        next_idx = '0;
        top_idx  = '0;
        run_end  = 1'b1;
      end else begin
        next_idx = next_idx + 16'd1;
      end
      r.last_of_run = run_end || !win_valid[next_idx % prw_pkg::WINDOW_DEPTH];
      if (keep) due_results.push_back(r);
    end
  endfunction

  function automatic void check_result(prw_pkg::out_item_t want, prw_pkg::out_item_t got);
    if (got.result_kind !== want.result_kind) begin
      $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
      fails++;
    end
    if (got.out_index !== want.out_index) begin
      $error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
      fails++;
    end
    if (got.out_handle !== want.out_handle) begin
      $error("out_handle: expected %0d, got %0d", want.out_handle, got.out_handle);
      fails++;
    end
    if (got.frame_done !== want.frame_done) begin
      $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
      fails++;
    end
    if (got.dropped_count !== want.dropped_count) begin
      $error("dropped_count: expected %0d, got %0d", want.dropped_count, got.dropped_count);
      fails++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
      fails++;
    end
  endfunction

  // Result side: check each transaction, then stall at random
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (res_valid && !res_stall) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d index %0d", res.result_kind, res.out_index);
        fails++;
      end else begin
        check_result(due_results.pop_front(), res);
      end
      rx_draw = rx_idle ? $urandom_range(MAX_WAIT, 0) : 0;
      res_stall <= (rx_draw != 0);
      rx_wait   <= rx_draw;
    end else if (rx_wait > 0) begin
      res_stall <= (rx_wait > 1);
      rx_wait   <= rx_wait - 1;
    end else if (rx_idle && $urandom_range(7, 0) == 0) begin
      res_stall <= 1'b1;
      rx_wait   <= $urandom_range(MAX_WAIT, 1);
    end else begin
      res_stall <= 1'b0;
    end
  end

  function automatic void add_row(prw_pkg::in_item_t it, int nwant, prw_pkg::out_item_t want);
    stim_row_t row;
    row.item  = it;
    row.nwant = nwant;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // Off-nominal packet: clear, repeat, stale, beyond the window or anything at all
  function automatic prw_pkg::in_item_t noise_item(int unsigned base, int unsigned len);
    prw_pkg::in_item_t it;
    noise_t            pick;
    it   = pkt_of(prw_pkg::KIND_PACKET, 16'($urandom), 16'($urandom), 1'($urandom));
    pick = noise_t'($urandom_range(NZ_ANY, NZ_CLEAR));
    case (pick)
      NZ_CLEAR:  it.kind = prw_pkg::KIND_CLEAR;
      NZ_REPEAT: it.packet_index = 16'(base + $urandom_range(len - 1, 0));
      NZ_STALE: begin
        if (next_idx != 0) it.packet_index = 16'($urandom_range(next_idx - 1, 0));
      end
      NZ_BEYOND: it.packet_index = 16'(next_idx + prw_pkg::WINDOW_DEPTH +
                                       $urandom_range(7, 0));
      default: ;
    endcase
    return it;
  endfunction

  // Drives one transaction after a random gap; predicted at drive time, order is kept
  task automatic send_item(prw_pkg::in_item_t it, int nwant, prw_pkg::out_item_t want);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(MAX_WAIT, 0) : 0;
    if (gap != 0) begin
      pkt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    reorder_step(it, nwant == WANT_MODEL);
    if (nwant == WANT_ONE) due_results.push_back(want);
    pkt       <= it;
    pkt_valid <= 1'b1;
    do @(posedge clk); while (pkt_stall);
  endtask

  task automatic settle_drained();
    pkt_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int          k;
    int          lost_k;
    int          rand_sent;
    int unsigned base;
    int unsigned len;
    int unsigned j;
    int unsigned tmp;
    bit          finish_frame;
    int unsigned order[$];

    empty_window_model();
    foreach (win_handle[i]) win_handle[i] = '0;
    foreach (win_last[i]) win_last[i] = 1'b0;

    // Directed table
    add_row(pkt_of(prw_pkg::KIND_CLEAR, 16'h0000, 16'h0000, 1'b0), WANT_ONE,
            res_of(prw_pkg::RK_REPORT, 16'h0000, 16'h0000, 1'b0, 7'd0, 1'b1));
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'hFFFF, 16'hFFFF, 1'b1), WANT_ONE,
            res_of(prw_pkg::RK_REJECT, 16'hFFFF, 16'hFFFF, 1'b0, 7'd0, 1'b1));
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd64, 16'h1234, 1'b0), WANT_ONE,
            res_of(prw_pkg::RK_REJECT, 16'd64, 16'h1234, 1'b0, 7'd0, 1'b1));
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd63, 16'hAAAA, 1'b0), WANT_NONE, '0);
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd63, 16'h5555, 1'b1), WANT_ONE,
            res_of(prw_pkg::RK_REJECT, 16'd63, 16'h5555, 1'b0, 7'd0, 1'b1));
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd2, 16'h0002, 1'b0), WANT_NONE, '0);
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd1, 16'h0001, 1'b0), WANT_NONE, '0);
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd0, 16'h0000, 1'b0), WANT_MODEL, '0);
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd1, 16'hBEEF, 1'b0), WANT_ONE,
            res_of(prw_pkg::RK_REJECT, 16'd1, 16'hBEEF, 1'b0, 7'd0, 1'b1));
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd66, 16'h00FF, 1'b0), WANT_NONE, '0);
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd67, 16'hFF00, 1'b0), WANT_ONE,
            res_of(prw_pkg::RK_REJECT, 16'd67, 16'hFF00, 1'b0, 7'd0, 1'b1));
    add_row(pkt_of(prw_pkg::KIND_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1), WANT_MODEL, '0);
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd0, 16'hFFFF, 1'b1), WANT_ONE,
            res_of(prw_pkg::RK_RELEASE, 16'd0, 16'hFFFF, 1'b1, 7'd0, 1'b1));
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd3, 16'h0303, 1'b1), WANT_NONE, '0);
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd1, 16'h0101, 1'b0), WANT_NONE, '0);
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd2, 16'h0202, 1'b0), WANT_NONE, '0);
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd0, 16'h8000, 1'b0), WANT_MODEL, '0);
    add_row(pkt_of(prw_pkg::KIND_PACKET, 16'd0, 16'h7FFF, 1'b0), WANT_ONE,
            res_of(prw_pkg::RK_RELEASE, 16'd0, 16'h7FFF, 1'b0, 7'd0, 1'b1));
    add_row(pkt_of(prw_pkg::KIND_CLEAR, 16'h0000, 16'h0000, 1'b0), WANT_MODEL, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].nwant, dir_rows[r].want);
    settle_drained();

    // Random frames: shuffled packets with some noise, losses and clears
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      tx_idle = ($urandom_range(3, 0) != 0);
      rx_idle = ($urandom_range(3, 0) != 0);
      if ($urandom_range(7, 0) == 0) settle_drained();
      base = next_idx;
      len  = ($urandom_range(7, 0) == 0) ? $urandom_range(prw_pkg::WINDOW_DEPTH, 1)
                                        : $urandom_range(10, 1);
      if (base + len > 65536) len = 65536 - base;
      finish_frame = ($urandom_range(3, 0) != 0);
      lost_k       = ($urandom_range(5, 0) == 0) ? int'($urandom_range(len - 1, 0)) : -1;
      order.delete();
      for (k = 0; k < len; k++) order.push_back(base + k);
      for (k = order.size() - 1; k > 0; k--) begin
        j        = $urandom_range(k, 0);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      foreach (order[p]) begin
        if ($urandom_range(9, 0) == 0) begin
          send_item(noise_item(base, len), WANT_MODEL, '0);
          rand_sent++;
        end
        if (p != lost_k) begin
          send_item(pkt_of(prw_pkg::KIND_PACKET, 16'(order[p]), 16'($urandom),
                           finish_frame && order[p] == base + len - 1), WANT_MODEL, '0);
          rand_sent++;
        end
      end
      // A lost packet leaves a hole for the clear to count
      if (lost_k >= 0 || (!finish_frame && $urandom_range(2, 0) == 0)) begin
        send_item(pkt_of(prw_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom)),
                  WANT_MODEL, '0);
        rand_sent++;
      end
    end

    settle_drained();
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      fails++;
    end
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== packet_reorder_window.f =====
hw/rtl/prw_pkg.sv
hw/rtl/prw_ram.sv
hw/rtl/prw_datapath.sv
hw/rtl/prw_controller.sv
hw/rtl/packet_reorder_window.sv
hw/rtl/prw_checker.sv
tb/tb.sv
